// ===== design/i2cems_pkg.sv =====
// Shared types and command codes for the I2C EEPROM master sequencer.
package i2cems_pkg;

	typedef enum logic [2:0] {
		CMD_BEGIN      = 3'd0,
		CMD_START_SENT = 3'd1,
		CMD_BYTE_SENT  = 3'd2,
		CMD_BYTE_RCVD  = 3'd3,
		CMD_OTHER      = 3'd4,
		CMD_TIMEOUT    = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		REG_SLAVE_ADDR   = 3'd0,
		REG_WADDR_HIGH   = 3'd1,
		REG_WADDR_LOW    = 3'd2,
		REG_INIT_DIR     = 3'd3,
		REG_SEND_WADDR   = 3'd4,
		REG_RANDOM_READ  = 3'd5,
		REG_ACK_POLLING  = 3'd6,
		REG_DATA_LENGTH  = 3'd7
	} reg_idx_t;

	localparam logic [7:0] ADDR_MASK = 8'hFE;

	typedef struct packed {
		logic [7:0] slave_address;
		logic [7:0] word_addr_high;
		logic [7:0] word_addr_low;
		logic       initial_direction;
		logic       send_word_address;
		logic       random_read;
		logic       ack_polling;
		logic [7:0] data_length;
	} cfg_t;

	typedef struct packed {
		logic       busy;
		logic [7:0] byte_count;
		logic       second_addr_phase;
		logic       addr_pending;
		logic       restart_pending;
		logic       direction;
	} seq_state_t;

	typedef struct packed {
		logic [7:0] rx_index;
		logic [7:0] rx_data;
		logic       rx_valid;
		logic       busy_res;
		logic       bus_reset;
		logic       ack_level;
		logic       ack_write;
		logic       stop_request;
		logic       start_request;
		logic [7:0] tx_data;
		logic       tx_load;
	} result_t;

endpackage

// ===== design/i2cems_step.sv =====
// Next-state and result logic for one bus event of the sequencer.
module i2cems_step (
	input  i2cems_pkg::cfg_t       cfg,
	input  i2cems_pkg::seq_state_t cur,
	input  logic [2:0]             cmd,
	input  logic                   ack_seen,
	input  logic [7:0]             rx_byte,
	input  logic [7:0]             tx_byte,
	output i2cems_pkg::seq_state_t nxt,
	output i2cems_pkg::result_t    res
);
	import i2cems_pkg::*;

	logic       fail;
	logic [7:0] count_inc;

	assign count_inc = cur.byte_count + 8'd1;

	always_comb begin
		nxt  = cur;
		res  = '0;
		fail = 1'b0;
		unique case (cmd)
			CMD_BEGIN: begin
				nxt.busy              = 1'b1;
				nxt.direction         = cfg.initial_direction;
				nxt.addr_pending      = cfg.send_word_address;
				nxt.second_addr_phase = 1'b0;
				nxt.restart_pending   = 1'b0;
				res.start_request     = 1'b1;
			end
			CMD_START_SENT: begin
				res.tx_load    = 1'b1;
				res.tx_data    = (cfg.slave_address & ADDR_MASK) | {7'd0, cur.direction};
				nxt.byte_count = 8'd0;
			end
			CMD_BYTE_SENT: begin
				if (!ack_seen) begin
					// A NACK either retries the whole transfer or aborts it.
					if (cfg.ack_polling) begin
						res.start_request = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end else if (cur.restart_pending) begin
					res.start_request   = 1'b1;
					nxt.restart_pending = 1'b0;
				end else if (cur.addr_pending) begin
					res.tx_load = 1'b1;
					if (cur.second_addr_phase) begin
						nxt.addr_pending = 1'b0;
						res.tx_data      = cfg.word_addr_low;
						if (cfg.random_read) begin
							nxt.restart_pending = 1'b1;
							nxt.direction       = 1'b1;
						end
					end else begin
						res.tx_data           = cfg.word_addr_high;
						nxt.second_addr_phase = 1'b1;
					end
				end else if (!cur.direction) begin
					if (cur.byte_count < cfg.data_length) begin
						res.tx_load    = 1'b1;
						res.tx_data    = tx_byte;
						nxt.byte_count = count_inc;
					end else begin
						res.stop_request      = 1'b1;
						nxt.busy              = 1'b0;
						nxt.second_addr_phase = 1'b0;
					end
				end
			end
			CMD_BYTE_RCVD: begin
				if (cur.byte_count < cfg.data_length) begin
					res.rx_valid   = 1'b1;
					res.rx_data    = rx_byte;
					res.rx_index   = cur.byte_count;
					nxt.byte_count = count_inc;
					res.ack_write  = 1'b1;
					res.ack_level  = 1'b1;
				end
				// The last byte (or a zero length) gets NACK and stop.
				if (nxt.byte_count == cfg.data_length) begin
					nxt.busy              = 1'b0;
					res.ack_write         = 1'b1;
					res.ack_level         = 1'b0;
					nxt.second_addr_phase = 1'b0;
					res.stop_request      = 1'b1;
				end
			end
			CMD_TIMEOUT: begin
				res.bus_reset = 1'b1;
				nxt.busy      = 1'b0;
			end
			default: begin
				fail = 1'b1;
			end
		endcase

		if (fail) begin
			res.bus_reset     = 1'b1;
			res.start_request = 1'b0;
			res.stop_request  = 1'b0;
			res.ack_write     = 1'b1;
			res.ack_level     = 1'b0;
			nxt.busy          = 1'b0;
		end
		res.busy_res = nxt.busy;
	end

endmodule

// ===== design/i2c_eeprom_master_sequencer.sv =====
// Top level of the I2C EEPROM master sequencer: registers, handshakes, result register.
//
// Each input beat on the s_ channel is one bus event from the I2C controller:
// a begin command, start sent, byte sent (with the slave ACK), byte received,
// another status, or a timeout. For every input beat exactly one result beat
// leaves on the m_ channel, telling the controller what to load, whether to
// request start or stop, which acknowledge to drive and whether to reset the bus.
// The event is decoded against the sequencer state in the cycle it is accepted and
// the result sits in the output register the next cycle.
// Throughput is one event per cycle; the output register is the only stage, so
// the input is taken whenever that register is empty or being drained.
// A stalled receiver holds the result and stops further input until it is taken.
// The configuration channel writes one register per beat (index 0..7) and is
// always ready; write it only while no event is in flight.
// Reset clears the sequencer state (not busy, write direction, count zero) and
// loads the register defaults: slave address 0xA0, word address sending on,
// data length one.
module i2c_eeprom_master_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// Event input. tuser: cmd[2:0].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,
	// tdata: ack_seen[0], rx_byte[8:1], tx_byte[16:9], zero fill[23:17].
	input  logic [23:0] s_tdata,
	// Result output.
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: tx_load[0], tx_data[8:1], start_request[9], stop_request[10],
	// ack_write[11], ack_level[12], bus_reset[13], busy_res[14], rx_valid[15],
	// rx_data[23:16], rx_index[31:24].
	output logic [31:0] m_tdata
);
	import i2cems_pkg::*;

	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	result_t    res_nxt;
	result_t    res_q;
	logic       out_valid_q;
	logic       in_fire;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign in_fire   = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = res_q;

	i2cems_step u_step (
		.cfg      (cfg_q),
		.cur      (state_q),
		.cmd      (s_tuser),
		.ack_seen (s_tdata[0]),
		.rx_byte  (s_tdata[8:1]),
		.tx_byte  (s_tdata[16:9]),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address     <= 8'hA0;
			cfg_q.word_addr_high    <= 8'd0;
			cfg_q.word_addr_low     <= 8'd0;
			cfg_q.initial_direction <= 1'b0;
			cfg_q.send_word_address <= 1'b1;
			cfg_q.random_read       <= 1'b0;
			cfg_q.ack_polling       <= 1'b0;
			cfg_q.data_length       <= 8'd1;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SLAVE_ADDR:  cfg_q.slave_address     <= cfg_data;
				REG_WADDR_HIGH:  cfg_q.word_addr_high    <= cfg_data;
				REG_WADDR_LOW:   cfg_q.word_addr_low     <= cfg_data;
				REG_INIT_DIR:    cfg_q.initial_direction <= cfg_data[0];
				REG_SEND_WADDR:  cfg_q.send_word_address <= cfg_data[0];
				REG_RANDOM_READ: cfg_q.random_read       <= cfg_data[0];
				REG_ACK_POLLING: cfg_q.ack_polling       <= cfg_data[0];
				REG_DATA_LENGTH: cfg_q.data_length       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_nxt;
		end
	end

	a_begin_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_tuser == CMD_BEGIN |=> state_q.busy && res_q.start_request)
		else $error("begin did not arm the transfer");

	a_timeout_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_tuser == CMD_TIMEOUT |=> !state_q.busy && res_q.bus_reset)
		else $error("timeout did not reset the bus and clear busy");

	a_busy_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> res_q.busy_res == state_q.busy)
		else $error("reported busy differs from sequencer state");

	a_bus_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.bus_reset |-> !res_q.start_request && !res_q.stop_request
			&& !res_q.busy_res)
		else $error("bus reset combined with start or stop");

	a_ack_level_gated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.ack_write |-> !res_q.ack_level)
		else $error("acknowledge level without acknowledge write");

endmodule
